FILE: hw/rtl/peer_access_ban_table_core_defines.svh
// Assertion macros used by the core RTL.
`ifndef PEER_ACCESS_BAN_TABLE_CORE_DEFINES_SVH
`define PEER_ACCESS_BAN_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PABT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PABT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pabt_pkg.sv
package pabt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam logic [1:0] KIND_ALLOW = 2'd0;
	localparam logic [1:0] KIND_DENY  = 2'd1;
	localparam logic [1:0] KIND_TEMP  = 2'd2;

	localparam logic [1:0] FN_CHECK  = 2'd0;
	localparam logic [1:0] FN_ALLOW  = 2'd1;
	localparam logic [1:0] FN_DENY   = 2'd2;
	localparam logic [1:0] FN_REPORT = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [2:0] REG_WHITELIST = 3'd0;
	localparam logic [2:0] REG_BAN_EN    = 3'd1;
	localparam logic [2:0] REG_LIMIT     = 3'd2;
	localparam logic [2:0] REG_WINDOW    = 3'd3;
	localparam logic [2:0] REG_TEMP_LEN  = 3'd4;

	typedef struct packed {
		logic [63:0] key;
		logic [1:0]  kind;
		logic [31:0] expiry;
		logic [31:0] seen_at;
		logic [15:0] viol;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EXEC
	} state_t;

	function automatic logic [31:0] inc32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

FILE: hw/rtl/pabt_ram.sv
module pabt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/peer_access_ban_table_core.sv
// Each item is handled by a full scan of the entry RAM (one read per cycle),
// then the drain and update states; the result is registered at update.
// A new item is accepted only in idle, once the previous item has retired;
// the update state holds while an earlier result is still pending.
// Reset (arst_n low, asynchronous): all entries invalid, counters and
// config registers zero, no result pending. Entry RAM contents are not cleared.
`include "peer_access_ban_table_core_defines.svh"

module peer_access_ban_table_core (
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // func[1:0], peer_address[65:2],
	                                // current_time[97:66], ban_length[129:98]
	// results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // access_kind[1:0], status[3:2],
	                                // violations_of_peer[19:4],
	                                // allowed_total[51:20], denied_total[83:52],
	                                // temp_banned_total[115:84],
	                                // violations_total[147:116]
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int N  = pabt_pkg::TABLE_ENTRIES;
	localparam int IW = pabt_pkg::IDX_W;

	// config registers
	logic        whitelist_q, ban_en_q;
	logic [15:0] limit_q;
	logic [31:0] window_q, temp_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whitelist_q <= 1'b0;
			ban_en_q    <= 1'b0;
			limit_q     <= '0;
			window_q    <= '0;
			temp_len_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pabt_pkg::REG_WHITELIST: whitelist_q <= cfg_data[0];
				pabt_pkg::REG_BAN_EN:    ban_en_q    <= cfg_data[0];
				pabt_pkg::REG_LIMIT:     limit_q     <= cfg_data[15:0];
				pabt_pkg::REG_WINDOW:    window_q    <= cfg_data;
				pabt_pkg::REG_TEMP_LEN:  temp_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// FSM
	pabt_pkg::state_t state_q, state_d;
	logic [IW-1:0]    scan_cnt_q;
	logic             go;   // update cycle may retire the item

	assign s_tready = (state_q == pabt_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pabt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pabt_pkg::S_IDLE:  if (s_tvalid) state_d = pabt_pkg::S_SCAN;
			pabt_pkg::S_SCAN:  if (scan_cnt_q == IW'(N - 1)) state_d = pabt_pkg::S_DRAIN;
			pabt_pkg::S_DRAIN: state_d = pabt_pkg::S_EXEC;
			pabt_pkg::S_EXEC:  if (go) state_d = pabt_pkg::S_IDLE;
			default:           state_d = pabt_pkg::S_IDLE;
		endcase
	end

	// latched item
	logic [1:0]  func_q;
	logic [63:0] key_q;
	logic [31:0] now_q, blen_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tdata[1:0];
			key_q  <= s_tdata[65:2];
			now_q  <= s_tdata[97:66];
			blen_q <= s_tdata[129:98];
		end
	end

	// entry RAM; valid bits in flops
	logic [N-1:0]        valid_q;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	pabt_pkg::entry_t    ram_wdata, ram_rdata;

	pabt_ram #(
		.WIDTH($bits(pabt_pkg::entry_t)),
		.DEPTH(N)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_cnt_q),
		.rdata(ram_rdata)
	);

	// scan: read issued at scan_cnt_q, compared in the next cycle
	logic             rd_vld_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic             hit_q, free_fnd_q;
	logic [IW-1:0]    hit_idx_q, free_idx_q;
	pabt_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			free_fnd_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == pabt_pkg::S_SCAN);
			if (s_tvalid && s_tready) begin
				scan_cnt_q <= '0;
				hit_q      <= 1'b0;
				free_fnd_q <= 1'b0;
			end else begin
				if (state_q == pabt_pkg::S_SCAN) begin
					scan_cnt_q <= scan_cnt_q + IW'(1);
					if (!valid_q[scan_cnt_q] && !free_fnd_q) begin
						free_fnd_q <= 1'b1;
					end
				end
				if (rd_vld_s1 && valid_q[rd_idx_s1] && ram_rdata.key == key_q && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q;
		if (state_q == pabt_pkg::S_SCAN && !valid_q[scan_cnt_q] && !free_fnd_q) begin
			free_idx_q <= scan_cnt_q;
		end
		if (rd_vld_s1 && valid_q[rd_idx_s1] && ram_rdata.key == key_q && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
			ent_q     <= ram_rdata;
		end
	end

	// update
	logic [31:0] allowed_q, denied_q, temp_q, vtotal_q;
	logic [31:0] allowed_d, denied_d, temp_d, vtotal_d;
	logic        m_tvalid_q;
	logic [1:0]  kind_d, status_d;
	logic [15:0] viol_d;
	logic        wr, set_v, clr_v;
	logic [IW-1:0] widx;
	pabt_pkg::entry_t ne;
	logic [1:0]  dflt, dkind;
	logic [31:0] dexp;

	assign go = (state_q == pabt_pkg::S_EXEC) && (!m_tvalid_q || m_tready);

	always_comb begin
		dflt      = whitelist_q ? pabt_pkg::KIND_DENY : pabt_pkg::KIND_ALLOW;
		dkind     = (blen_q != '0) ? pabt_pkg::KIND_TEMP : pabt_pkg::KIND_DENY;
		dexp      = (blen_q != '0) ? pabt_pkg::add_sat(now_q, blen_q) : '0;
		ne        = ent_q;
		wr        = 1'b0;
		set_v     = 1'b0;
		clr_v     = 1'b0;
		widx      = hit_idx_q;
		kind_d    = dflt;
		status_d  = pabt_pkg::ST_DONE;
		viol_d    = '0;
		allowed_d = allowed_q;
		denied_d  = denied_q;
		temp_d    = temp_q;
		vtotal_d  = vtotal_q;
		unique case (func_q)
			pabt_pkg::FN_CHECK: begin
				if (hit_q) begin
					if (ent_q.kind == pabt_pkg::KIND_TEMP && ent_q.expiry != '0 &&
					    now_q > ent_q.expiry) begin
						clr_v = 1'b1;
					end else begin
						kind_d = ent_q.kind;
						viol_d = ent_q.viol;
					end
				end
			end
			pabt_pkg::FN_ALLOW: begin
				if (hit_q) begin
					ne.kind   = pabt_pkg::KIND_ALLOW;
					ne.expiry = '0;
					wr        = 1'b1;
				end else if (free_fnd_q) begin
					ne.key     = key_q;
					ne.kind    = pabt_pkg::KIND_ALLOW;
					ne.expiry  = '0;
					ne.seen_at = '0;
					ne.viol    = '0;
					wr         = 1'b1;
					set_v      = 1'b1;
					widx       = free_idx_q;
					allowed_d  = pabt_pkg::inc32(allowed_q);
				end else begin
					status_d = pabt_pkg::ST_FULL;
				end
				if (wr) begin
					kind_d = ne.kind;
					viol_d = ne.viol;
				end
			end
			pabt_pkg::FN_DENY: begin
				if (hit_q) begin
					ne.kind   = dkind;
					ne.expiry = dexp;
					ne.viol   = pabt_pkg::inc16(ent_q.viol);
					wr        = 1'b1;
				end else if (free_fnd_q) begin
					ne.key     = key_q;
					ne.kind    = dkind;
					ne.expiry  = dexp;
					ne.seen_at = '0;
					ne.viol    = 16'd1;
					wr         = 1'b1;
					set_v      = 1'b1;
					widx       = free_idx_q;
					if (blen_q != '0) begin
						temp_d = pabt_pkg::inc32(temp_q);
					end else begin
						denied_d = pabt_pkg::inc32(denied_q);
					end
				end else begin
					status_d = pabt_pkg::ST_FULL;
				end
				if (wr) begin
					kind_d = ne.kind;
					viol_d = ne.viol;
				end
			end
			pabt_pkg::FN_REPORT: begin
				if (!ban_en_q) begin
					status_d = pabt_pkg::ST_IGNORED;
					if (hit_q) begin
						kind_d = ent_q.kind;
						viol_d = ent_q.viol;
					end
				end else begin
					vtotal_d = pabt_pkg::inc32(vtotal_q);
					if (hit_q) begin
						ne.viol = pabt_pkg::inc16(ent_q.viol);
						wr      = 1'b1;
					end else if (free_fnd_q) begin
						ne.key     = key_q;
						ne.kind    = pabt_pkg::KIND_ALLOW;
						ne.expiry  = '0;
						ne.seen_at = now_q;
						ne.viol    = 16'd1;
						wr         = 1'b1;
						set_v      = 1'b1;
						widx       = free_idx_q;
					end else begin
						status_d = pabt_pkg::ST_FULL;
					end
					if (wr) begin
						if (ne.viol >= limit_q) begin
							// permanent if still inside the window since first seen
							if (now_q >= ne.seen_at &&
							    (now_q - ne.seen_at) <= window_q) begin
								ne.kind   = pabt_pkg::KIND_DENY;
								ne.expiry = '0;
							end else begin
								ne.kind   = pabt_pkg::KIND_TEMP;
								ne.expiry = pabt_pkg::add_sat(now_q, temp_len_q);
							end
						end
						kind_d = ne.kind;
						viol_d = ne.viol;
					end
				end
			end
			default: ;
		endcase
	end

	assign ram_we    = go && wr;
	assign ram_waddr = widx;
	assign ram_wdata = ne;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			allowed_q  <= '0;
			denied_q   <= '0;
			temp_q     <= '0;
			vtotal_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (go) begin
				if (set_v) valid_q[widx] <= 1'b1;
				if (clr_v) valid_q[widx] <= 1'b0;
				allowed_q  <= allowed_d;
				denied_q   <= denied_d;
				temp_q     <= temp_d;
				vtotal_q   <= vtotal_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_tdata <= {4'd0, vtotal_d, temp_d, denied_d, allowed_d, viol_d, status_d, kind_d};
		end
	end

	assign m_tvalid = m_tvalid_q;

	// checks
	`PABT_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, s_tvalid && s_tready,
		state_q == pabt_pkg::S_SCAN, "accepted item did not start a scan")
	`PABT_ASSERT_NOW(a_hit_is_valid, clk, arst_n, state_q == pabt_pkg::S_EXEC && hit_q,
		valid_q[hit_idx_q], "matched entry is not valid at update")
	`PABT_ASSERT_NOW(a_free_is_free, clk, arst_n, state_q == pabt_pkg::S_EXEC && free_fnd_q,
		!valid_q[free_idx_q], "chosen free slot is occupied")
	`PABT_ASSERT_NOW(a_no_write_stalled, clk, arst_n, m_tvalid && !m_tready,
		!ram_we, "entry written while previous result still pending")

endmodule
